// ----- src/deque_with_search_defines.svh -----
// assertion macros for the deque with search checker
`ifndef DEQUE_WITH_SEARCH_DEFINES_SVH
`define DEQUE_WITH_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/deq_pkg.sv -----
// types and constants shared by the deque with search
`default_nettype none

package deq_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        word_t      value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        word_t      data_out;
        logic [5:0] position;
        logic [6:0] occupancy;
    } out_beat_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_WRITE,
        CELL_LOAD,
        CELL_LANE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    value;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN_BACK,
        S_SCAN_SEARCH
    } state_t;

endpackage

`default_nettype wire

// ----- src/deq_cell.sv -----
// one storage cell of the deque chain with its read lane
`default_nettype none

module deq_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  wire logic               aclk,
    input  wire deq_pkg::cell_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]   count,
    input  wire deq_pkg::word_t     left_data,
    input  wire deq_pkg::word_t     right_data,
    input  wire deq_pkg::word_t     right_lane,
    input  wire logic               right_flag,
    output deq_pkg::word_t          data,
    output deq_pkg::word_t          lane,
    output logic                    flag
);

    deq_pkg::word_t data_reg;
    deq_pkg::word_t lane_reg;
    logic           flag_reg;

    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            deq_pkg::CELL_HOLD: begin
            end
            deq_pkg::CELL_SHIFT_R: begin
                data_reg <= left_data;
            end
            deq_pkg::CELL_SHIFT_L: begin
                data_reg <= right_data;
            end
            deq_pkg::CELL_WRITE: begin
                if (count == CNT_W'(INDEX)) begin
                    data_reg <= ctrl.value;
                end
            end
            deq_pkg::CELL_LOAD: begin
                lane_reg <= data_reg;
                flag_reg <= (data_reg == ctrl.value) && (CNT_W'(INDEX) < count);
            end
            deq_pkg::CELL_LANE: begin
                lane_reg <= right_lane;
                flag_reg <= right_flag;
            end
            default: begin
            end
        endcase
    end

    assign data = data_reg;
    assign lane = lane_reg;
    assign flag = flag_reg;

endmodule

`default_nettype wire

// ----- src/deque_with_search.sv -----
// Bounded double-ended queue of signed 32-bit values with search, built as a
// chain of DEPTH cells in which cell 0 always holds the front entry. Push
// front, push back and pop front need no scan: the result is ready the
// cycle after the input beat is taken. Pop back and search copy the cells into
// a read lane that moves one cell toward the front per clock; pop back ends
// when the back entry reaches the lane of cell 0, and a search ends at the
// first match there or, on a miss, when the back entry has reached it. A new
// command is taken once the previous one is finished and the output register
// is free or being emptied in the same cycle.
`default_nettype none

module deque_with_search #(
    parameter int DEPTH = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire deq_pkg::in_beat_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output deq_pkg::out_beat_t     m_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    deq_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      counter_reg, counter_next;
    logic               out_valid_reg, out_valid_next;
    deq_pkg::out_beat_t out_reg, out_next;
    logic               out_load;
    deq_pkg::cell_ctrl_t ctrl;

    deq_pkg::word_t cell_data [DEPTH];
    deq_pkg::word_t cell_lane [DEPTH];
    logic           cell_flag [DEPTH];

    logic               full;
    logic               empty;
    logic [IW-1:0]      last_idx;
    logic [IW+5:0]      pos_wide;
    logic [CW+6:0]      occ_wide;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            deq_pkg::word_t left_in;
            deq_pkg::word_t right_in;
            deq_pkg::word_t right_lane_in;
            logic           right_flag_in;
            if (i == 0) begin : g_first
                assign left_in = ctrl.value;
            end else begin : g_inner_l
                assign left_in = cell_data[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_in      = '0;
                assign right_lane_in = '0;
                assign right_flag_in = 1'b0;
            end else begin : g_inner_r
                assign right_in      = cell_data[i+1];
                assign right_lane_in = cell_lane[i+1];
                assign right_flag_in = cell_flag[i+1];
            end
            deq_cell #(
                .CNT_W (CW),
                .INDEX (i)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .left_data  (left_in),
                .right_data (right_in),
                .right_lane (right_lane_in),
                .right_flag (right_flag_in),
                .data       (cell_data[i]),
                .lane       (cell_lane[i]),
                .flag       (cell_flag[i])
            );
        end
    endgenerate

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_idx = IW'(count_reg - CW'(1));
    assign s_ready  = (state_reg == deq_pkg::S_IDLE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        ctrl.op      = deq_pkg::CELL_HOLD;
        ctrl.value   = s_data.value;
        out_load     = 1'b0;
        out_next     = '0;
        pos_wide     = {6'b0, counter_reg};
        unique case (state_reg)
            deq_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    out_load = 1'b1;
                    unique case (s_data.command)
                        deq_pkg::CMD_PUSH_FRONT: begin
                            if (full) begin
                                out_next.status = deq_pkg::ST_FULL;
                            end else begin
                                ctrl.op    = deq_pkg::CELL_SHIFT_R;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::CMD_PUSH_BACK: begin
                            if (full) begin
                                out_next.status = deq_pkg::ST_FULL;
                            end else begin
                                ctrl.op    = deq_pkg::CELL_WRITE;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (empty) begin
                                out_next.status = deq_pkg::ST_EMPTY;
                            end else begin
                                ctrl.op           = deq_pkg::CELL_SHIFT_L;
                                out_next.data_out = cell_data[0];
                                count_next        = count_reg - CW'(1);
                            end
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            if (empty) begin
                                out_next.status = deq_pkg::ST_EMPTY;
                            end else begin
                                out_load     = 1'b0;
                                ctrl.op      = deq_pkg::CELL_LOAD;
                                counter_next = '0;
                                state_next   = deq_pkg::S_SCAN_BACK;
                            end
                        end
                        deq_pkg::CMD_SEARCH: begin
                            if (empty) begin
                                out_next.status = deq_pkg::ST_NOT_FOUND;
                            end else begin
                                out_load     = 1'b0;
                                ctrl.op      = deq_pkg::CELL_LOAD;
                                counter_next = '0;
                                state_next   = deq_pkg::S_SCAN_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            deq_pkg::S_SCAN_BACK: begin
                if (counter_reg == last_idx) begin
                    out_load          = 1'b1;
                    out_next.data_out = cell_lane[0];
                    count_next        = count_reg - CW'(1);
                    state_next        = deq_pkg::S_IDLE;
                end else begin
                    ctrl.op      = deq_pkg::CELL_LANE;
                    counter_next = counter_reg + IW'(1);
                end
            end
            deq_pkg::S_SCAN_SEARCH: begin
                priority if (cell_flag[0]) begin
                    out_load          = 1'b1;
                    out_next.position = pos_wide[5:0];
                    state_next        = deq_pkg::S_IDLE;
                end else if (counter_reg == last_idx) begin
                    out_load        = 1'b1;
                    out_next.status = deq_pkg::ST_NOT_FOUND;
                    state_next      = deq_pkg::S_IDLE;
                end else begin
                    ctrl.op      = deq_pkg::CELL_LANE;
                    counter_next = counter_reg + IW'(1);
                end
            end
            default: begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
        occ_wide           = {7'b0, count_next};
        out_next.occupancy = occ_wide[6:0];
        out_valid_next     = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= deq_pkg::S_IDLE;
            count_reg     <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- src/deq_checker.sv -----
// port-level checks for the deque with search, bound to the top level
`default_nettype none

`include "deque_with_search_defines.svh"

module deq_checker #(
    parameter int DEPTH = 64
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire deq_pkg::in_beat_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire deq_pkg::out_beat_t m_data
);

    logic small_depth;
    logic failed;

    assign small_depth = (DEPTH < 128);
    assign failed      = (m_data.status == deq_pkg::ST_EMPTY) ||
                         (m_data.status == deq_pkg::ST_FULL) ||
                         (m_data.status == deq_pkg::ST_NOT_FOUND);

    `DEQ_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data),
        "result beat changed while stalled")

    `DEQ_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data),
        "input beat changed while waiting")

    `DEQ_ASSERT(a_fail_zero, m_valid && failed,
        (m_data.data_out == '0) && (m_data.position == '0),
        "failed command returned nonzero data or position")

    `DEQ_ASSERT(a_empty_occ, m_valid && (m_data.status == deq_pkg::ST_EMPTY),
        m_data.occupancy == '0, "empty status with nonzero occupancy")

    `DEQ_ASSERT(a_full_occ, m_valid && small_depth && (m_data.status == deq_pkg::ST_FULL),
        m_data.occupancy == 7'(DEPTH), "full status without full occupancy")

endmodule

bind deque_with_search deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- test/deque_with_search_tb.sv -----
// self-checking testbench for deque_with_search against a local deque model
`default_nettype none

module deque_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int ITEMS = 1850;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int TAIL_CYCLES = 100;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    deq_pkg::in_beat_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    deq_pkg::out_beat_t m_data;

    deque_with_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // model of the deque
    deq_pkg::word_t store [DEPTH];
    logic [5:0]     front_slot = '0;
    int             fill_level = 0;

    deq_pkg::in_beat_t  commands_to_send [$];
    deq_pkg::out_beat_t replies_due [$];

    int items_made = 0;
    int errors = 0;
    int replies_seen = 0;
    int send_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    bit stim_done = 1'b0;

    int n_full = 0;
    int n_empty = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_ignored = 0;
    int deepest_hit = 0;
    int peak_fill = 0;

    function automatic deq_pkg::out_beat_t deque_apply(deq_pkg::in_beat_t beat);
        deq_pkg::out_beat_t r;
        logic [5:0]         slot;
        r = '0;
        r.status = deq_pkg::ST_OK;
        case (beat.command)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (fill_level == DEPTH) begin
                    r.status = deq_pkg::ST_FULL;
                end else begin
                    front_slot = front_slot - 6'd1;
                    store[front_slot] = beat.value;
                    fill_level++;
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (fill_level == DEPTH) begin
                    r.status = deq_pkg::ST_FULL;
                end else begin
                    slot = 6'(front_slot + fill_level);
                    store[slot] = beat.value;
                    fill_level++;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (fill_level == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                end else begin
                    r.data_out = store[front_slot];
                    front_slot = front_slot + 6'd1;
                    fill_level--;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                end else begin
                    slot = 6'(front_slot + fill_level - 1);
                    r.data_out = store[slot];
                    fill_level--;
                end
            end
            deq_pkg::CMD_SEARCH: begin
                r.status = deq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < fill_level; i++) begin
                    if (store[6'(front_slot + i)] == beat.value) begin
                        r.status = deq_pkg::ST_OK;
                        r.position = 6'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = 7'(fill_level);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic deq_pkg::word_t pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return deq_pkg::word_t'(32'h8000_0000);
                    1: return deq_pkg::word_t'(32'h7fff_ffff);
                    2: return deq_pkg::word_t'(32'h0000_0000);
                    default: return deq_pkg::word_t'(32'hffff_ffff);
                endcase
            end
            1, 2, 3, 4: return deq_pkg::word_t'(int'($urandom_range(0, 15)) - 8);
            default: return deq_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] either_push();
        return $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] either_pop();
        return $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
    endfunction

    task automatic queue_item(logic [2:0] op, deq_pkg::word_t val);
        deq_pkg::in_beat_t beat;
        beat.command = op;
        beat.value = val;
        commands_to_send.push_back(beat);
        items_made++;
    endtask

    task automatic random_block(int push_w, int pop_w, int count);
        int         roll;
        logic [2:0] op;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < push_w) op = either_push();
            else if (roll < push_w + pop_w) op = either_pop();
            else if (roll < 96) op = deq_pkg::CMD_SEARCH;
            else op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            queue_item(op, pick_value());
        end
    endtask

    // empty it, fill with distinct values, overflow, search both ends, empty again
    task automatic full_cycle();
        deq_pkg::word_t base;
        base = deq_pkg::word_t'($urandom);
        repeat (DEPTH + 4) queue_item(either_pop(), deq_pkg::word_t'($urandom));
        for (int i = 0; i < DEPTH; i++)
            queue_item(deq_pkg::CMD_PUSH_BACK, base + deq_pkg::word_t'(i));
        queue_item(either_push(), pick_value());
        queue_item(deq_pkg::CMD_SEARCH, base + deq_pkg::word_t'(DEPTH - 1));
        queue_item(deq_pkg::CMD_SEARCH, base);
        queue_item(deq_pkg::CMD_SEARCH, pick_value());
        repeat (DEPTH + 2) queue_item(either_pop(), deq_pkg::word_t'($urandom));
    endtask

    function automatic bit idle_allowed();
        return !(stim_done && commands_to_send.size() < 150);
    endfunction

    always @(posedge aclk) begin : drive_beats
        deq_pkg::out_beat_t reply;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                reply = deque_apply(s_data);
                replies_due.push_back(reply);
                if (reply.status == deq_pkg::ST_FULL) n_full++;
                if (reply.status == deq_pkg::ST_EMPTY) n_empty++;
                if (reply.status == deq_pkg::ST_NOT_FOUND) n_miss++;
                if (s_data.command == deq_pkg::CMD_SEARCH && reply.status == deq_pkg::ST_OK) begin
                    n_hit++;
                    if (reply.position > deepest_hit) deepest_hit = reply.position;
                end
                if (s_data.command > deq_pkg::CMD_SEARCH) n_ignored++;
                if (fill_level > peak_fill) peak_fill = fill_level;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (commands_to_send.size() != 0 && idle_allowed()
                             && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 17);
                    s_valid <= 1'b0;
                end else if (commands_to_send.size() != 0) begin
                    s_data <= commands_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_beats
        deq_pkg::out_beat_t got;
        deq_pkg::out_beat_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = m_data;
                replies_seen++;
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              replies_seen));
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  replies_seen, got.status, want.status));
                    if (got.data_out !== want.data_out)
                        report_mismatch($sformatf("result %0d data_out %0h, expected %0h",
                                                  replies_seen, got.data_out, want.data_out));
                    if (got.position !== want.position)
                        report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                                  replies_seen, got.position, want.position));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                                                  replies_seen, got.occupancy, want.occupancy));
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long receiver stall
    always @(posedge aclk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    initial begin : stimulus
        int waited;
        queue_item(deq_pkg::CMD_POP_FRONT, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_BACK, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(0));
        queue_item(CMD_UNUSED_LO, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_PUSH_BACK, deq_pkg::word_t'(32'h7fff_ffff));
        queue_item(deq_pkg::CMD_PUSH_FRONT, deq_pkg::word_t'(32'h8000_0000));
        queue_item(deq_pkg::CMD_PUSH_BACK, deq_pkg::word_t'(0));
        queue_item(deq_pkg::CMD_PUSH_BACK, deq_pkg::word_t'(-1));
        queue_item(deq_pkg::CMD_PUSH_FRONT, deq_pkg::word_t'(32'h8000_0000));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(32'h8000_0000));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(-1));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(32'h7fff_ffff));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(12345));
        queue_item(3'd6, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_BACK, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_FRONT, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_SEARCH, deq_pkg::word_t'(0));
        queue_item(CMD_UNUSED_HI, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_BACK, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_BACK, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_FRONT, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_POP_BACK, deq_pkg::word_t'($urandom));
        queue_item(deq_pkg::CMD_PUSH_FRONT, deq_pkg::word_t'(32'h5a5a_5a5a));
        queue_item(deq_pkg::CMD_POP_FRONT, deq_pkg::word_t'($urandom));

        // sender pauses until the directed part has fully drained
        wait (aresetn);
        while (commands_to_send.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);

        random_block(50, 30, 90);
        @(posedge aclk);
        hold_left <= HOLD_CYCLES;
        full_cycle();

        while (items_made < ITEMS) begin
            case ($urandom_range(0, 9))
                0: full_cycle();
                1, 2, 3: random_block(75, 15, $urandom_range(20, 70));
                4, 5, 6: random_block(20, 65, $urandom_range(20, 70));
                default: random_block(40, 40, $urandom_range(20, 60));
            endcase
        end
        stim_done <= 1'b1;

        while (commands_to_send.size() != 0 || s_valid) @(posedge aclk);
        waited = 0;
        while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        while (replies_due.size() != 0) begin
            void'(replies_due.pop_front());
            report_mismatch("expected result never arrived");
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d commands: %0d full pushes, %0d empty pops, peak fill %0d",
                 items_made, n_full, n_empty, peak_fill);
        $display("searches: %0d hits (deepest position %0d), %0d misses; %0d unused codes",
                 n_hit, deepest_hit, n_miss, n_ignored);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/deq_pkg.sv
src/deq_cell.sv
src/deque_with_search.sv
src/deq_checker.sv
test/deque_with_search_tb.sv
